// ----- sv/dkst_pkg.sv -----
// Package: constants, codes and record types of the dual-key sorted device table.
package dkst_pkg;

   localparam int CAPACITY  = 64;
   localparam int INTF_BITS = 8;
   localparam int ADDR_W    = $clog2(CAPACITY);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int UID_W     = 64;
   localparam int VID_W     = 16;

   localparam logic [2:0] ACT_INSERT     = 3'd0;
   localparam logic [2:0] ACT_EDIT       = 3'd1;
   localparam logic [2:0] ACT_REMOVE     = 3'd2;
   localparam logic [2:0] ACT_UNLIST     = 3'd3;
   localparam logic [2:0] ACT_LOOKUP_UID = 3'd4;
   localparam logic [2:0] ACT_LOOKUP_VID = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_UID_NF = 2'd1;
   localparam logic [1:0] ST_VID_NF = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef struct packed {
      logic [UID_W-1:0]     uid;
      logic [VID_W-1:0]     vid;
      logic [INTF_BITS-1:0] intf;
      logic                 root;
      logic                 user;
   } entry_type;

   typedef struct packed {
      logic [VID_W-1:0] vid;
      addr_type         slot;
   } vrec_type;

endpackage

// ----- sv/dkst_req_if.sv -----
// Interface: request channel of the device table.
interface dkst_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [63:0] key_uid;
   logic [15:0] key_vid;
   logic [7:0]  interface_id;
   logic        has_root_key;
   logic        has_user_key;

   modport source (output valid, action, key_uid, key_vid, interface_id,
                   has_root_key, has_user_key, input ready);
   modport sink (input valid, action, key_uid, key_vid, interface_id,
                 has_root_key, has_user_key, output ready);
endinterface

// ----- sv/dkst_rsp_if.sv -----
// Interface: response channel of the device table.
interface dkst_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [63:0] found_uid;
   logic [15:0] found_vid;
   logic [7:0]  found_interface;
   logic        root_present;
   logic        user_present;
   logic [6:0]  entry_count;

   modport source (output valid, status, found_uid, found_vid, found_interface,
                   root_present, user_present, entry_count, input ready);
   modport sink (input valid, status, found_uid, found_vid, found_interface,
                 root_present, user_present, entry_count, output ready);
endinterface

// ----- sv/dkst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dkst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/dual_key_sorted_device_table.sv -----
// Top level: sorted device table with unique-id and short-id indexes.
//
// Requests arrive on req_chan (valid/ready); one response per request leaves
// on rsp_chan. csr_wr_en/csr_wr_data set the short id reported when no entry
// is selected; write it only while the table is idle.
// Requests are handled one at a time by a sequencer around three RAMs (entry
// store, uid order, short-id index). A binary search over the uid order reads
// the order RAM and then the entry store for each probe (up to 7 probes); one
// over the short-id index reads only the index for each probe. Inserts and
// removals shift the ordered arrays one element at a time, reading and then
// writing each moved element.
// req_chan.ready is high only when the sequencer is idle.
// The response sits in an output register; a stalled receiver holds it and
// the next request is still taken and worked, waiting at the end until the
// register frees. Reset empties the table (all slots free, counts zero)
// and clears default short id to zero; RAM contents need no clearing.
module dual_key_sorted_device_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   dkst_req_if.sink          req_chan,
   dkst_rsp_if.source        rsp_chan
);
   import dkst_pkg::*;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_US_LOOP  = 5'd1;
   localparam logic [4:0] S_US_ORD   = 5'd2;
   localparam logic [4:0] S_US_ENT   = 5'd3;
   localparam logic [4:0] S_US_FORD  = 5'd4;
   localparam logic [4:0] S_US_FENT  = 5'd5;
   localparam logic [4:0] S_UID_DONE = 5'd6;
   localparam logic [4:0] S_VS_LOOP  = 5'd7;
   localparam logic [4:0] S_VS_ENT   = 5'd8;
   localparam logic [4:0] S_VS_FIN   = 5'd9;
   localparam logic [4:0] S_VS_DONE  = 5'd10;
   localparam logic [4:0] S_LK_ENT   = 5'd11;
   localparam logic [4:0] S_AV_START = 5'd12;
   localparam logic [4:0] S_AV_NEW   = 5'd13;
   localparam logic [4:0] S_AV_OTH   = 5'd14;
   localparam logic [4:0] S_AV_FINAL = 5'd15;
   localparam logic [4:0] S_RM_SH    = 5'd16;
   localparam logic [4:0] S_RM_WR    = 5'd17;
   localparam logic [4:0] S_IN_SH    = 5'd18;
   localparam logic [4:0] S_IN_WR    = 5'd19;
   localparam logic [4:0] S_VD_SH    = 5'd20;
   localparam logic [4:0] S_VD_WR    = 5'd21;
   localparam logic [4:0] S_VI_SH    = 5'd22;
   localparam logic [4:0] S_VI_WR    = 5'd23;
   localparam logic [4:0] S_OUT      = 5'd24;

   localparam logic [1:0] VR_LOOKUP  = 2'd0;
   localparam logic [1:0] VR_EDITCHK = 2'd1;
   localparam logic [1:0] VR_OLD     = 2'd2;
   localparam logic [1:0] VR_NEW     = 2'd3;

   localparam cnt_type CAP_CNT = cnt_type'(CAPACITY);

   logic [4:0]           state_ff, state_in;
   logic [2:0]           act_ff, act_in;
   logic [UID_W-1:0]     kuid_ff, kuid_in;
   logic [VID_W-1:0]     kvid_ff, kvid_in;
   logic [INTF_BITS-1:0] kintf_ff, kintf_in;
   logic                 kroot_ff, kroot_in;
   logic                 kuser_ff, kuser_in;
   cnt_type              lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   cnt_type              pos_ff, pos_in, i_ff, i_in;
   cnt_type              used_ff, used_in, vused_ff, vused_in;
   logic                 found_ff, found_in, vfound_ff, vfound_in;
   addr_type             slot_ff, slot_in, vslot_ff, vslot_in;
   entry_type            e_ff, e_in;
   logic [VID_W-1:0]     vnew_ff, vnew_in, vkey_ff, vkey_in;
   logic [1:0]           vret_ff, vret_in;
   logic [CAPACITY-1:0]  free_ff, free_in;
   logic [VID_W-1:0]     dvid_ff, dvid_in;
   logic [1:0]           st_ff, st_in;
   logic                 sel_ff, sel_in;
   logic                 ovalid_ff, ovalid_in;
   logic [1:0]           ostatus_ff, ostatus_in;
   entry_type            oent_ff, oent_in;
   cnt_type              ocount_ff, ocount_in;

   logic       ent_we, ent_re, ord_we, ord_re, vix_we, vix_re;
   addr_type   ent_wa, ent_ra, ord_wa, ord_ra, vix_wa, vix_ra;
   entry_type  ent_wd, ent_rd, new_e;
   addr_type   ord_wd, ord_rd;
   vrec_type   vix_wd, vix_rd;
   logic [CNT_W:0] lh_sum;
   cnt_type    mid_c, i_inc, i_dec;
   addr_type   free_idx;

   dkst_ram #(.WIDTH($bits(entry_type)), .DEPTH(CAPACITY)) u_entry_ram (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_wa), .wr_data(ent_wd),
      .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(ent_rd));

   dkst_ram #(.WIDTH(ADDR_W), .DEPTH(CAPACITY)) u_order_ram (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_en(ord_re), .rd_addr(ord_ra), .rd_data(ord_rd));

   dkst_ram #(.WIDTH($bits(vrec_type)), .DEPTH(CAPACITY)) u_vid_ram (
      .clock(clock), .wr_en(vix_we), .wr_addr(vix_wa), .wr_data(vix_wd),
      .rd_en(vix_re), .rd_addr(vix_ra), .rd_data(vix_rd));

   assign lh_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_c  = lh_sum[CNT_W:1];
   assign i_inc  = cnt_type'(i_ff + 1'b1);
   assign i_dec  = cnt_type'(i_ff - 1'b1);

   always_comb begin
      free_idx = '0;
      for (int k = CAPACITY - 1; k >= 0; k--) begin
         if (free_ff[k]) begin
            free_idx = addr_type'(k);
         end
      end
   end

   always_comb begin
      new_e = e_ff;
      new_e.vid = vnew_ff;
      if (act_ff == ACT_INSERT || act_ff == ACT_EDIT) begin
         new_e.intf = kintf_ff;
         new_e.root = kroot_ff;
         new_e.user = kuser_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff; kuid_in = kuid_ff; kvid_in = kvid_ff;
      kintf_in = kintf_ff; kroot_in = kroot_ff; kuser_in = kuser_ff;
      lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff; pos_in = pos_ff; i_in = i_ff;
      used_in = used_ff; vused_in = vused_ff;
      found_in = found_ff; vfound_in = vfound_ff;
      slot_in = slot_ff; vslot_in = vslot_ff; e_in = e_ff;
      vnew_in = vnew_ff; vkey_in = vkey_ff; vret_in = vret_ff;
      free_in = free_ff;
      dvid_in = csr_wr_en ? csr_wr_data : dvid_ff;
      st_in = st_ff; sel_in = sel_ff;
      ovalid_in = ovalid_ff && !rsp_chan.ready;
      ostatus_in = ostatus_ff; oent_in = oent_ff; ocount_in = ocount_ff;
      ent_we = 1'b0; ent_re = 1'b0; ent_wa = slot_ff; ent_ra = slot_ff; ent_wd = new_e;
      ord_we = 1'b0; ord_re = 1'b0; ord_wa = i_ff[ADDR_W-1:0];
      ord_ra = i_ff[ADDR_W-1:0]; ord_wd = ord_rd;
      vix_we = 1'b0; vix_re = 1'b0; vix_wa = i_ff[ADDR_W-1:0];
      vix_ra = i_ff[ADDR_W-1:0]; vix_wd = vix_rd;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               act_in = req_chan.action;
               kuid_in = req_chan.key_uid;
               kvid_in = req_chan.key_vid;
               kintf_in = req_chan.interface_id;
               kroot_in = req_chan.has_root_key;
               kuser_in = req_chan.has_user_key;
               lo_in = '0;
               hi_in = used_ff;
               sel_in = 1'b0;
               st_in = ST_OK;
               unique case (req_chan.action) inside
                  ACT_INSERT, ACT_EDIT, ACT_REMOVE, ACT_LOOKUP_UID: begin
                     state_in = S_US_LOOP;
                  end
                  ACT_UNLIST, ACT_LOOKUP_VID: begin
                     if (req_chan.key_vid == '0) begin
                        st_in = ST_VID_NF;
                        state_in = S_OUT;
                     end else begin
                        hi_in = vused_ff;
                        vkey_in = req_chan.key_vid;
                        vret_in = VR_LOOKUP;
                        state_in = S_VS_LOOP;
                     end
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_US_LOOP: begin
            if (lo_ff < hi_ff) begin
               mid_in = mid_c;
               ord_re = 1'b1;
               ord_ra = mid_c[ADDR_W-1:0];
               state_in = S_US_ORD;
            end else if (lo_ff < used_ff) begin
               ord_re = 1'b1;
               ord_ra = lo_ff[ADDR_W-1:0];
               state_in = S_US_FORD;
            end else begin
               found_in = 1'b0;
               state_in = S_UID_DONE;
            end
         end
         S_US_ORD: begin
            ent_re = 1'b1;
            ent_ra = ord_rd;
            state_in = S_US_ENT;
         end
         S_US_ENT: begin
            if (ent_rd.uid < kuid_ff) begin
               lo_in = cnt_type'(mid_ff + 1'b1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_US_LOOP;
         end
         S_US_FORD: begin
            slot_in = ord_rd;
            ent_re = 1'b1;
            ent_ra = ord_rd;
            state_in = S_US_FENT;
         end
         S_US_FENT: begin
            found_in = (ent_rd.uid == kuid_ff);
            e_in = ent_rd;
            state_in = S_UID_DONE;
         end
         S_UID_DONE: begin
            pos_in = lo_ff;
            unique case (act_ff) inside
               ACT_LOOKUP_UID: begin
                  st_in = found_ff ? ST_OK : ST_UID_NF;
                  sel_in = found_ff;
                  state_in = S_OUT;
               end
               ACT_REMOVE: begin
                  if (!found_ff) begin
                     st_in = ST_UID_NF;
                     state_in = S_OUT;
                  end else begin
                     vnew_in = '0;
                     state_in = S_AV_START;
                  end
               end
               ACT_EDIT: begin
                  if (!found_ff) begin
                     st_in = ST_UID_NF;
                     state_in = S_OUT;
                  end else if (kvid_ff != '0) begin
                     lo_in = '0;
                     hi_in = vused_ff;
                     vkey_in = kvid_ff;
                     vret_in = VR_EDITCHK;
                     state_in = S_VS_LOOP;
                  end else begin
                     vnew_in = kvid_ff;
                     state_in = S_AV_START;
                  end
               end
               ACT_INSERT: begin
                  if (found_ff) begin
                     vnew_in = kvid_ff;
                     state_in = S_AV_START;
                  end else if (used_ff >= CAP_CNT) begin
                     st_in = ST_FULL;
                     state_in = S_OUT;
                  end else begin
                     slot_in = free_idx;
                     free_in[free_idx] = 1'b0;
                     e_in = '{uid: kuid_ff, vid: '0, intf: '0, root: 1'b0, user: 1'b0};
                     ent_we = 1'b1;
                     ent_wa = free_idx;
                     ent_wd = '{uid: kuid_ff, vid: '0, intf: '0, root: 1'b0, user: 1'b0};
                     i_in = used_ff;
                     state_in = S_IN_SH;
                  end
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_VS_LOOP: begin
            if (lo_ff < hi_ff) begin
               mid_in = mid_c;
               vix_re = 1'b1;
               vix_ra = mid_c[ADDR_W-1:0];
               state_in = S_VS_ENT;
            end else if (lo_ff < vused_ff) begin
               vix_re = 1'b1;
               vix_ra = lo_ff[ADDR_W-1:0];
               state_in = S_VS_FIN;
            end else begin
               vfound_in = 1'b0;
               state_in = S_VS_DONE;
            end
         end
         S_VS_ENT: begin
            if (vix_rd.vid < vkey_ff) begin
               lo_in = cnt_type'(mid_ff + 1'b1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_VS_LOOP;
         end
         S_VS_FIN: begin
            vfound_in = (vix_rd.vid == vkey_ff);
            vslot_in = vix_rd.slot;
            state_in = S_VS_DONE;
         end
         S_VS_DONE: begin
            unique case (vret_ff)
               VR_LOOKUP: begin
                  if (!vfound_ff) begin
                     st_in = ST_VID_NF;
                     state_in = S_OUT;
                  end else begin
                     slot_in = vslot_ff;
                     ent_re = 1'b1;
                     ent_ra = vslot_ff;
                     state_in = S_LK_ENT;
                  end
               end
               VR_EDITCHK: begin
                  if (!vfound_ff) begin
                     st_in = ST_VID_NF;
                     state_in = S_OUT;
                  end else begin
                     vnew_in = kvid_ff;
                     state_in = S_AV_START;
                  end
               end
               VR_OLD: begin
                  if (vfound_ff) begin
                     i_in = lo_ff;
                     state_in = S_VD_SH;
                  end else begin
                     state_in = S_AV_NEW;
                  end
               end
               default: begin
                  if (vfound_ff) begin
                     ent_re = 1'b1;
                     ent_ra = vslot_ff;
                     state_in = S_AV_OTH;
                  end else if (vused_ff < CAP_CNT) begin
                     i_in = vused_ff;
                     state_in = S_VI_SH;
                  end else begin
                     state_in = S_AV_FINAL;
                  end
               end
            endcase
         end
         S_LK_ENT: begin
            e_in = ent_rd;
            if (act_ff == ACT_UNLIST) begin
               vnew_in = '0;
               state_in = S_AV_START;
            end else begin
               sel_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_AV_START: begin
            if (e_ff.vid == vnew_ff) begin
               state_in = S_AV_FINAL;
            end else if (e_ff.vid != '0) begin
               lo_in = '0;
               hi_in = vused_ff;
               vkey_in = e_ff.vid;
               vret_in = VR_OLD;
               state_in = S_VS_LOOP;
            end else begin
               state_in = S_AV_NEW;
            end
         end
         S_AV_NEW: begin
            if (vnew_ff != '0) begin
               lo_in = '0;
               hi_in = vused_ff;
               vkey_in = vnew_ff;
               vret_in = VR_NEW;
               state_in = S_VS_LOOP;
            end else begin
               state_in = S_AV_FINAL;
            end
         end
         S_AV_OTH: begin
            ent_we = 1'b1;
            ent_wa = vslot_ff;
            ent_wd = ent_rd;
            ent_wd.vid = '0;
            vix_we = 1'b1;
            vix_wa = lo_ff[ADDR_W-1:0];
            vix_wd = '{vid: vkey_ff, slot: slot_ff};
            state_in = S_AV_FINAL;
         end
         S_AV_FINAL: begin
            ent_we = 1'b1;
            ent_wa = slot_ff;
            ent_wd = new_e;
            if (act_ff == ACT_REMOVE) begin
               i_in = pos_ff;
               state_in = S_RM_SH;
            end else begin
               e_in = new_e;
               sel_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_RM_SH: begin
            if (i_inc < used_ff) begin
               ord_re = 1'b1;
               ord_ra = i_inc[ADDR_W-1:0];
               state_in = S_RM_WR;
            end else begin
               used_in = cnt_type'(used_ff - 1'b1);
               free_in[slot_ff] = 1'b1;
               sel_in = 1'b1;
               state_in = S_OUT;
            end
         end
         S_RM_WR: begin
            ord_we = 1'b1;
            i_in = i_inc;
            state_in = S_RM_SH;
         end
         S_IN_SH: begin
            if (i_ff > pos_ff) begin
               ord_re = 1'b1;
               ord_ra = i_dec[ADDR_W-1:0];
               state_in = S_IN_WR;
            end else begin
               ord_we = 1'b1;
               ord_wa = pos_ff[ADDR_W-1:0];
               ord_wd = slot_ff;
               used_in = cnt_type'(used_ff + 1'b1);
               vnew_in = kvid_ff;
               state_in = S_AV_START;
            end
         end
         S_IN_WR: begin
            ord_we = 1'b1;
            i_in = i_dec;
            state_in = S_IN_SH;
         end
         S_VD_SH: begin
            if (i_inc < vused_ff) begin
               vix_re = 1'b1;
               vix_ra = i_inc[ADDR_W-1:0];
               state_in = S_VD_WR;
            end else begin
               vused_in = cnt_type'(vused_ff - 1'b1);
               state_in = S_AV_NEW;
            end
         end
         S_VD_WR: begin
            vix_we = 1'b1;
            i_in = i_inc;
            state_in = S_VD_SH;
         end
         S_VI_SH: begin
            if (i_ff > lo_ff) begin
               vix_re = 1'b1;
               vix_ra = i_dec[ADDR_W-1:0];
               state_in = S_VI_WR;
            end else begin
               vix_we = 1'b1;
               vix_wa = lo_ff[ADDR_W-1:0];
               vix_wd = '{vid: vnew_ff, slot: slot_ff};
               vused_in = cnt_type'(vused_ff + 1'b1);
               state_in = S_AV_FINAL;
            end
         end
         S_VI_WR: begin
            vix_we = 1'b1;
            i_in = i_dec;
            state_in = S_VI_SH;
         end
         S_OUT: begin
            if (!ovalid_ff || rsp_chan.ready) begin
               ovalid_in = 1'b1;
               ostatus_in = st_ff;
               ocount_in = used_ff;
               if (sel_ff) begin
                  oent_in = e_ff;
               end else begin
                  oent_in = '{uid: '0, vid: dvid_ff, intf: '0, root: 1'b0, user: 1'b0};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         used_ff   <= '0;
         vused_ff  <= '0;
         free_ff   <= '1;
         dvid_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         vused_ff  <= vused_in;
         free_ff   <= free_in;
         dvid_ff   <= dvid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in; kuid_ff <= kuid_in; kvid_ff <= kvid_in;
      kintf_ff <= kintf_in; kroot_ff <= kroot_in; kuser_ff <= kuser_in;
      lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in; pos_ff <= pos_in; i_ff <= i_in;
      found_ff <= found_in; vfound_ff <= vfound_in;
      slot_ff <= slot_in; vslot_ff <= vslot_in; e_ff <= e_in;
      vnew_ff <= vnew_in; vkey_ff <= vkey_in; vret_ff <= vret_in;
      st_ff <= st_in; sel_ff <= sel_in;
      ostatus_ff <= ostatus_in; oent_ff <= oent_in; ocount_ff <= ocount_in;
   end

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = ovalid_ff;
   assign rsp_chan.status          = ostatus_ff;
   assign rsp_chan.found_uid       = oent_ff.uid;
   assign rsp_chan.found_vid       = oent_ff.vid;
   assign rsp_chan.found_interface = oent_ff.intf;
   assign rsp_chan.root_present    = oent_ff.root;
   assign rsp_chan.user_present    = oent_ff.user;
   assign rsp_chan.entry_count     = ocount_ff;
endmodule
